FILE: src/ccd_pkg.sv
// Shared constants, types and helper functions for the current deposit unit.
`timescale 1ns / 1ps
package ccd_pkg;

  // Grid and field geometry
  localparam int GRID_CELLS = 1024;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int N_W        = ADDR_W + 1;
  localparam int ACC_W      = 48;
  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = 10;
  localparam int CIU_W      = 11;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int MEM_W      = 2 * ACC_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_DEPOSIT = OP_W'(1);
  localparam logic [OP_W-1:0] OP_READ    = OP_W'(2);

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = ST_W'(0);
  localparam logic [ST_W-1:0] ST_OFF_GRID  = ST_W'(1);
  localparam logic [ST_W-1:0] ST_BAD_INDEX = ST_W'(2);
  localparam logic [ST_W-1:0] ST_SAT       = ST_W'(3);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ION_CHARGE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ELEC_CHARGE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CELLS       = CFG_IDX_W'(3);

  // Configuration reset values
  localparam logic [WORD_W-1:0] RST_INV_SPACING = 32'h0001_0000;
  localparam logic [WORD_W-1:0] RST_ION_CHARGE  = 32'h0001_0000;
  localparam logic [WORD_W-1:0] RST_ELEC_CHARGE = 32'hFFFF_0000;
  localparam logic [CIU_W-1:0]  RST_CELLS       = CIU_W'(1024);

  // Load strobes for one share unit
  typedef struct packed {
    logic load_qv;
    logic load_hi;
    logic load_lo;
  } share_ctl_t;

  // Saturating accumulator sum
  typedef struct packed {
    logic             sat;
    logic [ACC_W-1:0] val;
  } acc_sum_t;

  // Scaled read result
  typedef struct packed {
    logic              sat;
    logic [WORD_W-1:0] val;
  } scale_res_t;

  // Add two accumulator values, clamp to the signed accumulator range
  function automatic acc_sum_t sat_add(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    acc_sum_t       r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r.sat = 1'b1;
      r.val = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r.sat = 1'b0;
      r.val = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // Clamp the programmed cell count to the supported range
  function automatic logic [N_W-1:0] active_cells(input logic [CIU_W-1:0] c);
    logic [N_W-1:0] n;
    if (c < CIU_W'(2)) begin
      n = N_W'(2);
    end else if (int'(c) > GRID_CELLS) begin
      n = N_W'(GRID_CELLS);
    end else begin
      n = N_W'(c);
    end
    return n;
  endfunction

endpackage

FILE: src/ccd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ccd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/ccd_share.sv
// Charge-weighted velocity and its split between two neighboring cells.
`timescale 1ns / 1ps
module ccd_share
  import ccd_pkg::*;
(
  input  logic                     clk,
  input  share_ctl_t               ctl,
  input  logic signed [WORD_W-1:0] charge,
  input  logic signed [WORD_W-1:0] vel,
  input  logic [FRAC_W-1:0]        frac,
  output logic [ACC_W-1:0]         hi_share,
  output logic [ACC_W-1:0]         lo_share
);

  logic signed [2*WORD_W-1:0]      qv_full;
  logic signed [ACC_W+FRAC_W:0]    hi_full;
  logic signed [ACC_W-1:0]         qv_r;
  logic signed [ACC_W-1:0]         hi_r;
  logic signed [ACC_W-1:0]         lo_r;

  // Q32.32 product, floor to Q32.16 by dropping low bits
  assign qv_full = charge * vel;
  // Share of the upper cell: qv * f, floor by 2^16
  assign hi_full = qv_r * $signed({1'b0, frac});

  // Advance through the three product stages
  always_ff @(posedge clk) begin
    if (ctl.load_qv) begin
      qv_r <= qv_full[2*WORD_W-1:FRAC_W];
    end
    if (ctl.load_hi) begin
      hi_r <= hi_full[ACC_W+FRAC_W-1:FRAC_W];
    end
    if (ctl.load_lo) begin
      lo_r <= qv_r - hi_r;
    end
  end

  assign hi_share = hi_r;
  assign lo_share = lo_r;

endmodule

FILE: src/ccd_scale.sv
// Scales a cell sum by the inverse spacing and saturates it to 32 bits.
`timescale 1ns / 1ps
module ccd_scale
  import ccd_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ACC_W:0]    val,
  input  logic [WORD_W-1:0] inv,
  output scale_res_t        res
);

  localparam int LO_W = 24;
  localparam int HI_W = ACC_W + 1 - LO_W;
  localparam int R_W  = WORD_W + 9;

  logic [ACC_W:0]           mag;
  logic                     neg_r;
  logic [HI_W+WORD_W-1:0]   p_hi_r;
  logic [LO_W+WORD_W-1:0]   p_lo_r;
  logic                     over;
  logic [R_W-1:0]           sum;
  logic [R_W-1:0]           lim;
  logic [WORD_W-1:0]        mag_o;

  // Magnitude of the sum
  assign mag = val[ACC_W] ? (~val + 1'b1) : val;

  // Register the split partial products
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= val[ACC_W];
      p_hi_r <= mag[ACC_W:LO_W] * inv;
      p_lo_r <= mag[LO_W-1:0] * inv;
    end
  end

  // Combine, clamp to the signed range and restore the sign
  always_comb begin
    over  = |p_hi_r[HI_W+WORD_W-1:WORD_W-1];
    sum   = R_W'({p_hi_r[WORD_W-2:0], 8'h00}) + R_W'(p_lo_r[LO_W+WORD_W-1:FRAC_W]);
    lim   = neg_r ? R_W'(32'h8000_0000) : R_W'(32'h7FFF_FFFF);
    res.sat = 1'b0;
    if (over || (sum > lim)) begin
      res.sat = 1'b1;
      mag_o   = lim[WORD_W-1:0];
    end else begin
      mag_o   = sum[WORD_W-1:0];
    end
    res.val = neg_r ? (~mag_o + 1'b1) : mag_o;
  end

endmodule

FILE: src/cic_current_deposit_unit.sv
// Top level: sequencer, cell store and datapath of the current deposit unit.
`timescale 1ns / 1ps
// One-dimensional cloud-in-cell current deposit on a periodic grid.
// Requests enter on the in_ channel (valid/ready); each request gives exactly
// one result on the out_ channel (valid/ready). Registers are written on the
// cfg_ channel, which is always ready; write them only while the unit is idle.
// Operations: clear one cell, deposit one particle, read one cell's current.
// The cell sums live in one memory (x and y side by side, registered read).
// The unit works on one request at a time; from accept to the next accept it
// runs the memory read-modify-write sequence: clear DECODE, FINISH; deposit
//   DECODE, DEP1 to DEP4, FINISH (off grid DEP1 to FINISH); read DECODE, RD1,
//   RD2 (second memory read, cell 0 or the last cell only), SC1, SC2, FINISH.
// A deposit reads and writes cell c and then cell c+1 on separate cycles.
// The result sits in an output register, so a new request is accepted while
// it waits; a following result holds the sequencer until out_ready frees it.
// After reset the unit runs a clearing pass over all GRID_CELLS entries, one
// per cycle, with in_ready low; register writes are taken.
module cic_current_deposit_unit
  import ccd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [WORD_W-1:0]        in_position,
  input  logic                     in_species,
  input  logic signed [WORD_W-1:0] in_velocity_x,
  input  logic signed [WORD_W-1:0] in_velocity_y,
  input  logic [IDX_W-1:0]         in_cell_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_current_x,
  output logic signed [WORD_W-1:0] out_current_y,
  output logic [ST_W-1:0]          out_status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WORD_W-1:0]        cfg_data
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_DEP1   = 4'd3;
  localparam logic [3:0] S_DEP2   = 4'd4;
  localparam logic [3:0] S_DEP3   = 4'd5;
  localparam logic [3:0] S_DEP4   = 4'd6;
  localparam logic [3:0] S_RD1    = 4'd7;
  localparam logic [3:0] S_RD2    = 4'd8;
  localparam logic [3:0] S_SC1    = 4'd9;
  localparam logic [3:0] S_SC2    = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;

  logic [3:0]               state_r;
  logic [3:0]               state_nxt;
  logic [ADDR_W-1:0]        clr_cnt_r;

  // Configuration
  logic [WORD_W-1:0]        inv_r;
  logic signed [WORD_W-1:0] ion_q_r;
  logic signed [WORD_W-1:0] elec_q_r;
  logic [CIU_W-1:0]         cells_r;

  // Request being worked on
  logic [OP_W-1:0]          op_r;
  logic [WORD_W-1:0]        pos_r;
  logic                     spec_r;
  logic signed [WORD_W-1:0] vx_r;
  logic signed [WORD_W-1:0] vy_r;
  logic [IDX_W-1:0]         idx_r;

  logic [WORD_W-1:0]        cell_r;
  logic [FRAC_W-1:0]        frac_r;
  logic                     wrap_r;
  logic                     sat_r;
  logic [ACC_W:0]           val_x_r;
  logic [ACC_W:0]           val_y_r;
  logic [WORD_W-1:0]        res_x_r;
  logic [WORD_W-1:0]        res_y_r;
  logic [ST_W-1:0]          st_r;

  logic                     out_valid_r;
  logic [WORD_W-1:0]        out_x_r;
  logic [WORD_W-1:0]        out_y_r;
  logic [ST_W-1:0]          out_st_r;

  logic                     in_fire;
  logic                     out_load;
  logic [N_W-1:0]           n_cells;
  logic [N_W-1:0]           n_last;
  logic                     idx_ok;
  logic                     wrap;
  logic                     off_grid;
  logic [ADDR_W-1:0]        cell_addr;
  logic [ADDR_W-1:0]        cell_addr_p1;
  logic [2*WORD_W-1:0]      pos_prod;
  logic signed [WORD_W-1:0] charge;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [MEM_W-1:0]         ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [MEM_W-1:0]         ram_rdata;
  logic [ACC_W-1:0]         rd_x;
  logic [ACC_W-1:0]         rd_y;

  share_ctl_t               share_ctl;
  logic [ACC_W-1:0]         hi_x;
  logic [ACC_W-1:0]         lo_x;
  logic [ACC_W-1:0]         hi_y;
  logic [ACC_W-1:0]         lo_y;
  acc_sum_t                 acc_x;
  acc_sum_t                 acc_y;
  scale_res_t               scl_x;
  scale_res_t               scl_y;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // Decode helpers
  assign n_cells      = active_cells(cells_r);
  assign n_last       = n_cells - 1'b1;
  assign idx_ok       = N_W'(idx_r) < n_cells;
  assign wrap         = (idx_r == '0) || (N_W'(idx_r) == n_last);
  assign off_grid     = cell_r >= WORD_W'(n_last);
  assign cell_addr    = cell_r[ADDR_W-1:0];
  assign cell_addr_p1 = cell_addr + ADDR_W'(1);
  assign pos_prod     = pos_r * inv_r;
  assign charge       = spec_r ? elec_q_r : ion_q_r;
  assign rd_x         = ram_rdata[ACC_W-1:0];
  assign rd_y         = ram_rdata[MEM_W-1:ACC_W];

  // Saturating accumulate of lower share (DEP3) or upper share (DEP4)
  assign acc_x = sat_add(rd_x, (state_r == S_DEP3) ? lo_x : hi_x);
  assign acc_y = sat_add(rd_y, (state_r == S_DEP3) ? lo_y : hi_y);

  // Memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = {acc_y.val, acc_x.val};
    ram_raddr = '0;
    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_DECODE: begin
        ram_we    = (op_r == OP_CLEAR) && idx_ok;
        ram_waddr = ADDR_W'(idx_r);
        ram_wdata = '0;
        ram_raddr = wrap ? '0 : ADDR_W'(idx_r);
      end
      S_DEP2: begin
        ram_raddr = cell_addr;
      end
      S_DEP3: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr;
        ram_raddr = cell_addr_p1;
      end
      S_DEP4: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr_p1;
      end
      S_RD1: begin
        ram_raddr = ADDR_W'(n_last);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Share unit strobes
  always_comb begin
    share_ctl.load_qv = (state_r == S_DECODE);
    share_ctl.load_hi = (state_r == S_DEP1);
    share_ctl.load_lo = (state_r == S_DEP2);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (clr_cnt_r == ADDR_W'(GRID_CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (op_r)
          OP_DEPOSIT: state_nxt = S_DEP1;
          OP_READ:    state_nxt = idx_ok ? S_RD1 : S_FINISH;
          default:    state_nxt = S_FINISH;
        endcase
      end
      S_DEP1:   state_nxt = off_grid ? S_FINISH : S_DEP2;
      S_DEP2:   state_nxt = S_DEP3;
      S_DEP3:   state_nxt = S_DEP4;
      S_DEP4:   state_nxt = S_FINISH;
      S_RD1:    state_nxt = wrap_r ? S_RD2 : S_SC1;
      S_RD2:    state_nxt = S_SC1;
      S_SC1:    state_nxt = S_SC2;
      S_SC2:    state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_INIT;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r    <= RST_INV_SPACING;
      ion_q_r  <= RST_ION_CHARGE;
      elec_q_r <= RST_ELEC_CHARGE;
      cells_r  <= RST_CELLS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INV_SPACING: inv_r    <= cfg_data;
        REG_ION_CHARGE:  ion_q_r  <= cfg_data;
        REG_ELEC_CHARGE: elec_q_r <= cfg_data;
        REG_CELLS:       cells_r  <= cfg_data[CIU_W-1:0];
        default:         inv_r    <= inv_r;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_operation;
      pos_r  <= in_position;
      spec_r <= in_species;
      vx_r   <= in_velocity_x;
      vy_r   <= in_velocity_y;
      idx_r  <= in_cell_index;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_DECODE: begin
        cell_r  <= pos_prod[2*WORD_W-1:WORD_W];
        frac_r  <= pos_prod[WORD_W-1:FRAC_W];
        wrap_r  <= wrap;
        sat_r   <= 1'b0;
        res_x_r <= '0;
        res_y_r <= '0;
        st_r    <= ((op_r == OP_CLEAR) || (op_r == OP_READ)) && !idx_ok ?
                   ST_BAD_INDEX : ST_OK;
      end
      S_DEP1: begin
        if (off_grid) st_r <= ST_OFF_GRID;
      end
      S_DEP3: begin
        sat_r <= acc_x.sat || acc_y.sat;
      end
      S_DEP4: begin
        st_r <= (sat_r || acc_x.sat || acc_y.sat) ? ST_SAT : ST_OK;
      end
      S_RD1: begin
        val_x_r <= {rd_x[ACC_W-1], rd_x};
        val_y_r <= {rd_y[ACC_W-1], rd_y};
      end
      S_RD2: begin
        val_x_r <= val_x_r + {rd_x[ACC_W-1], rd_x};
        val_y_r <= val_y_r + {rd_y[ACC_W-1], rd_y};
      end
      S_SC2: begin
        res_x_r <= scl_x.val;
        res_y_r <= scl_y.val;
        st_r    <= (scl_x.sat || scl_y.sat) ? ST_SAT : ST_OK;
      end
      default: begin
        sat_r <= sat_r;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r  <= res_x_r;
      out_y_r  <= res_y_r;
      out_st_r <= st_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_current_x = out_x_r;
  assign out_current_y = out_y_r;
  assign out_status    = out_st_r;

  // Cell store: {sum_y, sum_x}
  ccd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (GRID_CELLS)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ccd_share u_share_x (
    .clk      (clk),
    .ctl      (share_ctl),
    .charge   (charge),
    .vel      (vx_r),
    .frac     (frac_r),
    .hi_share (hi_x),
    .lo_share (lo_x)
  );

  ccd_share u_share_y (
    .clk      (clk),
    .ctl      (share_ctl),
    .charge   (charge),
    .vel      (vy_r),
    .frac     (frac_r),
    .hi_share (hi_y),
    .lo_share (lo_y)
  );

  ccd_scale u_scale_x (
    .clk (clk),
    .en  (state_r == S_SC1),
    .val (val_x_r),
    .inv (inv_r),
    .res (scl_x)
  );

  ccd_scale u_scale_y (
    .clk (clk),
    .en  (state_r == S_SC1),
    .val (val_y_r),
    .inv (inv_r),
    .res (scl_y)
  );

  // The lower-cell write and the upper-cell read never hit the same entry
  a_dep_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEP3) |-> (ram_waddr != ram_raddr))
    else $error("deposit write and read address collide");

  // A finished result waits while the output register is still occupied
  a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_ready) |=> (state_r == S_FINISH))
    else $error("result overwrote a pending output");

  // Dropped particles report no current
  a_off_grid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_OFF_GRID) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("off-grid result carries current");

  // No request is taken during the clearing pass
  a_init_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !in_ready && !out_valid_r)
    else $error("request or result during clearing pass");

endmodule
